@@ rtl/bta_pkg.sv @@
// shared constants, word types and controller/datapath command and status types
`default_nettype none
package bta_pkg;

    localparam int ARENA_WORDS = 1024;
    localparam int ADDR_W      = $clog2(ARENA_WORDS);
    localparam int SIZE_W      = $clog2(ARENA_WORDS + 1);

    localparam logic [SIZE_W-1:0] SLACK_RESET = SIZE_W'(10);

    localparam logic FUNC_ALLOC    = 1'b0;
    localparam logic FUNC_FREE     = 1'b1;
    localparam logic STATUS_DONE   = 1'b0;
    localparam logic STATUS_NO_FIT = 1'b1;

    typedef struct packed {
        logic              func;
        logic [SIZE_W-1:0] request_size;
        logic [ADDR_W-1:0] block_address;
    } in_word_t;

    typedef struct packed {
        logic              status;
        logic [ADDR_W-1:0] granted_address;
    } out_word_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CLEAR,
        OP_LOAD,
        OP_A_WALK,
        OP_A_WHOLE1,
        OP_A_WHOLE2,
        OP_A_SPLIT1,
        OP_A_SPLIT2,
        OP_A_SPLIT3,
        OP_F_CHECK,
        OP_F_LEFT,
        OP_F_RIGHT,
        OP_N1,
        OP_N2,
        OP_N3,
        OP_N4,
        OP_L1,
        OP_R1,
        OP_R2,
        OP_R3,
        OP_B1,
        OP_B2
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
        logic is_free;
        logic walk_fail;
        logic walk_fit;
        logic whole;
        logic bad_free;
        logic lf;
        logic rf;
        logic list_empty;
        logic single_r;
    } sts_t;

endpackage
`default_nettype wire

@@ rtl/bta_ctrl.sv @@
// controller state machine sequencing the heap micro-operations
`default_nettype none
module bta_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    output logic               done,
    output bta_pkg::cmd_t      cmd,
    input  wire bta_pkg::sts_t sts
);

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_A_WALK,
        S_A_WHOLE1,
        S_A_WHOLE2,
        S_A_SPLIT1,
        S_A_SPLIT2,
        S_A_SPLIT3,
        S_F_CHECK,
        S_F_LEFT,
        S_F_RIGHT,
        S_N1,
        S_N2,
        S_N3,
        S_N4,
        S_L1,
        S_R1,
        S_R2,
        S_R3,
        S_B1,
        S_B2
    } state_t;

    state_t state_reg, state_next;
    logic   done_reg, done_next;

    always_comb
    begin
        cmd.op     = bta_pkg::OP_NONE;
        state_next = state_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.op = bta_pkg::OP_CLEAR;
                if (sts.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.op     = bta_pkg::OP_LOAD;
                    state_next = sts.is_free ? S_F_CHECK : S_A_WALK;
                end
            end
            S_A_WALK:
            begin
                cmd.op = bta_pkg::OP_A_WALK;
                if (sts.walk_fail)
                begin
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                end
                else if (sts.walk_fit)
                begin
                    state_next = sts.whole ? S_A_WHOLE1 : S_A_SPLIT1;
                end
            end
            S_A_WHOLE1:
            begin
                cmd.op     = bta_pkg::OP_A_WHOLE1;
                state_next = S_A_WHOLE2;
            end
            S_A_WHOLE2:
            begin
                cmd.op     = bta_pkg::OP_A_WHOLE2;
                state_next = S_IDLE;
                done_next  = 1'b1;
            end
            S_A_SPLIT1:
            begin
                cmd.op     = bta_pkg::OP_A_SPLIT1;
                state_next = S_A_SPLIT2;
            end
            S_A_SPLIT2:
            begin
                cmd.op     = bta_pkg::OP_A_SPLIT2;
                state_next = S_A_SPLIT3;
            end
            S_A_SPLIT3:
            begin
                cmd.op     = bta_pkg::OP_A_SPLIT3;
                state_next = S_IDLE;
                done_next  = 1'b1;
            end
            S_F_CHECK:
            begin
                cmd.op = bta_pkg::OP_F_CHECK;
                if (sts.bad_free)
                begin
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                end
                else
                begin
                    state_next = S_F_LEFT;
                end
            end
            S_F_LEFT:
            begin
                cmd.op     = bta_pkg::OP_F_LEFT;
                state_next = S_F_RIGHT;
            end
            S_F_RIGHT:
            begin
                cmd.op = bta_pkg::OP_F_RIGHT;
                if (sts.lf && sts.rf)
                begin
                    state_next = S_B1;
                end
                else if (sts.lf)
                begin
                    state_next = S_L1;
                end
                else if (sts.rf)
                begin
                    state_next = S_R1;
                end
                else
                begin
                    state_next = S_N1;
                end
            end
            S_N1:
            begin
                cmd.op     = bta_pkg::OP_N1;
                state_next = S_N2;
            end
            S_N2:
            begin
                cmd.op = bta_pkg::OP_N2;
                if (sts.list_empty)
                begin
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                end
                else
                begin
                    state_next = S_N3;
                end
            end
            S_N3:
            begin
                cmd.op     = bta_pkg::OP_N3;
                state_next = S_N4;
            end
            S_N4:
            begin
                cmd.op     = bta_pkg::OP_N4;
                state_next = S_IDLE;
                done_next  = 1'b1;
            end
            S_L1:
            begin
                cmd.op     = bta_pkg::OP_L1;
                state_next = S_IDLE;
                done_next  = 1'b1;
            end
            S_R1:
            begin
                cmd.op     = bta_pkg::OP_R1;
                state_next = sts.single_r ? S_R3 : S_R2;
            end
            S_R2:
            begin
                cmd.op     = bta_pkg::OP_R2;
                state_next = S_R3;
            end
            S_R3:
            begin
                cmd.op     = bta_pkg::OP_R3;
                state_next = S_IDLE;
                done_next  = 1'b1;
            end
            S_B1:
            begin
                cmd.op     = bta_pkg::OP_B1;
                state_next = S_B2;
            end
            S_B2:
            begin
                cmd.op     = bta_pkg::OP_B2;
                state_next = S_IDLE;
                done_next  = 1'b1;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

endmodule
`default_nettype wire

@@ rtl/bta_datapath.sv @@
// arena stores, free list pointers and address arithmetic
`default_nettype none
module bta_datapath (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire bta_pkg::cmd_t               cmd,
    output bta_pkg::sts_t                    sts,
    input  wire bta_pkg::in_word_t           request,
    output bta_pkg::out_word_t               result,
    input  wire logic                        cfg_write_en,
    input  wire logic [bta_pkg::SIZE_W-1:0]  cfg_write_data
);

    localparam int AW    = bta_pkg::ADDR_W;
    localparam int SW    = bta_pkg::SIZE_W;
    localparam int UW    = bta_pkg::SIZE_W + 2;
    localparam int WORDS = bta_pkg::ARENA_WORDS;

    logic          tag_mem   [WORDS];
    logic [SW-1:0] size_mem  [WORDS];
    logic [AW-1:0] left_mem  [WORDS];
    logic [AW-1:0] right_mem [WORDS];

    logic          rd_tag_reg;
    logic [SW-1:0] rd_size_reg;
    logic [AW-1:0] rd_left_reg;
    logic [AW-1:0] rd_right_reg;

    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic               tag_we,   size_we,   left_we,   right_we;
    logic [AW-1:0]      tag_wa,   size_wa,   left_wa,   right_wa;
    logic               tag_wd;
    logic [SW-1:0]      size_wd;
    logic [AW-1:0]      left_wd,  right_wd;

    bta_pkg::in_word_t  req_reg;
    bta_pkg::out_word_t res_reg;
    logic [AW-1:0] p_reg, start_reg, k_reg, rover_reg, clr_reg;
    logic [AW-1:0] s_reg, q_reg, q1_reg;
    logic [SW-1:0] n_reg, tsize_reg, slack_reg;
    logic          empty_reg, lf_reg;

    logic [SW-1:0] n_req, left_over;
    logic          fit, walk_end, no_walk, alloc_single, rf, single_r;
    logic [UW-1:0] a_foot_sum, f2_sum, r_sum, ff_sum, mr_sum, fr_sum, fb_sum;
    logic [AW-1:0] a_foot, f2, q_split, r_addr, f_free, f_r, f_b;

    assign n_req        = req_reg.request_size;
    assign fit          = (rd_size_reg >= n_req);
    assign walk_end     = (rd_right_reg == start_reg) || (k_reg == AW'(WORDS - 1));
    assign no_walk      = empty_reg || (n_req == '0);
    assign left_over    = rd_size_reg - n_req;
    assign alloc_single = (rd_right_reg == p_reg);
    assign a_foot_sum   = UW'(p_reg) + UW'(rd_size_reg) - UW'(1);
    assign a_foot       = a_foot_sum[AW-1:0];
    assign f2_sum       = UW'(p_reg) + UW'(left_over) - UW'(1);
    assign f2           = f2_sum[AW-1:0];
    assign q_split      = f2 + AW'(1);
    assign r_sum        = UW'(p_reg) + UW'(n_reg);
    assign r_addr       = r_sum[AW-1:0];
    assign ff_sum       = r_sum - UW'(1);
    assign f_free       = ff_sum[AW-1:0];
    assign rf           = (r_sum < UW'(WORDS)) && !rd_tag_reg;
    assign single_r     = empty_reg || (q1_reg == r_addr);
    assign mr_sum       = UW'(n_reg) + UW'(tsize_reg);
    assign fr_sum       = UW'(p_reg) + mr_sum - UW'(1);
    assign f_r          = fr_sum[AW-1:0];
    assign fb_sum       = UW'(r_addr) + UW'(tsize_reg) - UW'(1);
    assign f_b          = fb_sum[AW-1:0];

    always_comb
    begin
        sts.clear_last = (clr_reg == AW'(WORDS - 1));
        sts.is_free    = (request.func == bta_pkg::FUNC_FREE);
        sts.walk_fail  = no_walk || (!fit && walk_end);
        sts.walk_fit   = !no_walk && fit;
        sts.whole      = (left_over <= slack_reg);
        sts.bad_free   = !rd_tag_reg || (rd_size_reg == '0) ||
                         (UW'(rd_size_reg) > (UW'(WORDS) - UW'(p_reg)));
        sts.lf         = lf_reg;
        sts.rf         = rf;
        sts.list_empty = empty_reg;
        sts.single_r   = single_r;
    end

    always_comb
    begin
        rd_en    = 1'b0;
        rd_addr  = '0;
        tag_we   = 1'b0;
        tag_wa   = '0;
        tag_wd   = 1'b0;
        size_we  = 1'b0;
        size_wa  = '0;
        size_wd  = '0;
        left_we  = 1'b0;
        left_wa  = '0;
        left_wd  = '0;
        right_we = 1'b0;
        right_wa = '0;
        right_wd = '0;
        unique case (cmd.op)
            bta_pkg::OP_CLEAR:
            begin
                tag_we   = 1'b1;
                tag_wa   = clr_reg;
                size_we  = 1'b1;
                size_wa  = clr_reg;
                size_wd  = (clr_reg == '0) ? SW'(WORDS) : '0;
                left_we  = 1'b1;
                left_wa  = clr_reg;
                right_we = 1'b1;
                right_wa = clr_reg;
            end
            bta_pkg::OP_LOAD:
            begin
                rd_en   = 1'b1;
                rd_addr = (request.func == bta_pkg::FUNC_FREE) ? request.block_address
                                                                : rover_reg;
            end
            bta_pkg::OP_A_WALK:
            begin
                if (!no_walk && !fit && !walk_end)
                begin
                    rd_en   = 1'b1;
                    rd_addr = rd_right_reg;
                end
            end
            bta_pkg::OP_A_WHOLE1:
            begin
                tag_we = 1'b1;
                tag_wa = p_reg;
                tag_wd = 1'b1;
                if (!alloc_single)
                begin
                    left_we  = 1'b1;
                    left_wa  = rd_right_reg;
                    left_wd  = rd_left_reg;
                    right_we = 1'b1;
                    right_wa = rd_left_reg;
                    right_wd = rd_right_reg;
                end
            end
            bta_pkg::OP_A_WHOLE2:
            begin
                tag_we = 1'b1;
                tag_wa = a_foot;
                tag_wd = 1'b1;
            end
            bta_pkg::OP_A_SPLIT1:
            begin
                tag_we  = 1'b1;
                tag_wa  = a_foot;
                tag_wd  = 1'b1;
                size_we = 1'b1;
                size_wa = p_reg;
                size_wd = left_over;
                left_we = 1'b1;
                left_wa = f2;
                left_wd = p_reg;
            end
            bta_pkg::OP_A_SPLIT2:
            begin
                tag_we  = 1'b1;
                tag_wa  = f2;
                size_we = 1'b1;
                size_wa = q_split;
                size_wd = n_req;
            end
            bta_pkg::OP_A_SPLIT3:
            begin
                tag_we = 1'b1;
                tag_wa = q_split;
                tag_wd = 1'b1;
            end
            bta_pkg::OP_F_CHECK:
            begin
                rd_en   = 1'b1;
                rd_addr = p_reg - AW'(1);
            end
            bta_pkg::OP_F_LEFT:
            begin
                rd_en   = 1'b1;
                rd_addr = r_addr;
            end
            bta_pkg::OP_F_RIGHT:
            begin
                rd_en   = 1'b1;
                rd_addr = s_reg;
            end
            bta_pkg::OP_N1:
            begin
                tag_we  = 1'b1;
                tag_wa  = p_reg;
                left_we = 1'b1;
                left_wa = f_free;
                left_wd = p_reg;
            end
            bta_pkg::OP_N2:
            begin
                tag_we = 1'b1;
                tag_wa = f_free;
                if (empty_reg)
                begin
                    left_we  = 1'b1;
                    left_wa  = p_reg;
                    left_wd  = p_reg;
                    right_we = 1'b1;
                    right_wa = p_reg;
                    right_wd = p_reg;
                end
                else
                begin
                    rd_en   = 1'b1;
                    rd_addr = rover_reg;
                end
            end
            bta_pkg::OP_N3:
            begin
                right_we = 1'b1;
                right_wa = p_reg;
                right_wd = rover_reg;
                left_we  = 1'b1;
                left_wa  = p_reg;
                left_wd  = rd_left_reg;
            end
            bta_pkg::OP_N4:
            begin
                right_we = 1'b1;
                right_wa = q_reg;
                right_wd = p_reg;
                left_we  = 1'b1;
                left_wa  = rover_reg;
                left_wd  = p_reg;
            end
            bta_pkg::OP_L1:
            begin
                size_we = 1'b1;
                size_wa = s_reg;
                size_wd = rd_size_reg + n_reg;
                left_we = 1'b1;
                left_wa = f_free;
                left_wd = s_reg;
                tag_we  = 1'b1;
                tag_wa  = f_free;
            end
            bta_pkg::OP_R1:
            begin
                tag_we  = 1'b1;
                tag_wa  = p_reg;
                size_we = 1'b1;
                size_wa = p_reg;
                size_wd = mr_sum[SW-1:0];
                left_we  = 1'b1;
                left_wa  = p_reg;
                right_we = 1'b1;
                if (single_r)
                begin
                    left_wd  = p_reg;
                    right_wa = p_reg;
                    right_wd = p_reg;
                end
                else
                begin
                    left_wd  = q_reg;
                    right_wa = q_reg;
                    right_wd = p_reg;
                end
            end
            bta_pkg::OP_R2:
            begin
                right_we = 1'b1;
                right_wa = p_reg;
                right_wd = q1_reg;
                left_we  = 1'b1;
                left_wa  = q1_reg;
                left_wd  = p_reg;
            end
            bta_pkg::OP_R3:
            begin
                left_we = 1'b1;
                left_wa = f_r;
                left_wd = p_reg;
                tag_we  = 1'b1;
                tag_wa  = f_r;
            end
            bta_pkg::OP_B1:
            begin
                size_we  = 1'b1;
                size_wa  = s_reg;
                size_wd  = rd_size_reg + n_reg + tsize_reg;
                right_we = 1'b1;
                right_wa = q_reg;
                right_wd = q1_reg;
                left_we  = 1'b1;
                left_wa  = q1_reg;
                left_wd  = q_reg;
            end
            bta_pkg::OP_B2:
            begin
                left_we = 1'b1;
                left_wa = f_b;
                left_wd = s_reg;
                tag_we  = 1'b1;
                tag_wa  = f_b;
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    // arena stores
    always_ff @(posedge clk)
    begin
        if (tag_we)
        begin
            tag_mem[tag_wa] <= tag_wd;
        end
        if (size_we)
        begin
            size_mem[size_wa] <= size_wd;
        end
        if (left_we)
        begin
            left_mem[left_wa] <= left_wd;
        end
        if (right_we)
        begin
            right_mem[right_wa] <= right_wd;
        end
        if (rd_en)
        begin
            rd_tag_reg   <= tag_mem[rd_addr];
            rd_size_reg  <= size_mem[rd_addr];
            rd_left_reg  <= left_mem[rd_addr];
            rd_right_reg <= right_mem[rd_addr];
        end
    end

    // list control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg   <= '0;
            rover_reg <= '0;
            empty_reg <= 1'b0;
            slack_reg <= bta_pkg::SLACK_RESET;
        end
        else
        begin
            if (cfg_write_en)
            begin
                slack_reg <= cfg_write_data;
            end
            case (cmd.op)
                bta_pkg::OP_CLEAR:
                begin
                    clr_reg <= clr_reg + AW'(1);
                end
                bta_pkg::OP_A_WHOLE1:
                begin
                    if (alloc_single)
                    begin
                        empty_reg <= 1'b1;
                        rover_reg <= '0;
                    end
                    else
                    begin
                        rover_reg <= rd_right_reg;
                    end
                end
                bta_pkg::OP_A_SPLIT1:
                begin
                    rover_reg <= rd_right_reg;
                end
                bta_pkg::OP_N2:
                begin
                    if (empty_reg)
                    begin
                        rover_reg <= p_reg;
                        empty_reg <= 1'b0;
                    end
                end
                bta_pkg::OP_N4:
                begin
                    rover_reg <= p_reg;
                end
                bta_pkg::OP_R1:
                begin
                    if (single_r)
                    begin
                        rover_reg <= p_reg;
                        empty_reg <= 1'b0;
                    end
                    else if (rover_reg == r_addr)
                    begin
                        rover_reg <= p_reg;
                    end
                end
                bta_pkg::OP_B1:
                begin
                    if (rover_reg == r_addr)
                    begin
                        rover_reg <= s_reg;
                    end
                end
                default:
                begin
                    clr_reg <= clr_reg;
                end
            endcase
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            bta_pkg::OP_LOAD:
            begin
                req_reg   <= request;
                p_reg     <= (request.func == bta_pkg::FUNC_FREE) ? request.block_address
                                                                  : rover_reg;
                start_reg <= rover_reg;
                k_reg     <= '0;
                res_reg.status          <= bta_pkg::STATUS_DONE;
                res_reg.granted_address <= '0;
            end
            bta_pkg::OP_A_WALK:
            begin
                if (no_walk)
                begin
                    res_reg.status <= bta_pkg::STATUS_NO_FIT;
                end
                else if (!fit)
                begin
                    if (walk_end)
                    begin
                        res_reg.status <= bta_pkg::STATUS_NO_FIT;
                    end
                    else
                    begin
                        p_reg <= rd_right_reg;
                        k_reg <= k_reg + AW'(1);
                    end
                end
            end
            bta_pkg::OP_A_WHOLE1:
            begin
                res_reg.granted_address <= p_reg;
            end
            bta_pkg::OP_A_SPLIT2:
            begin
                res_reg.granted_address <= q_split;
            end
            bta_pkg::OP_F_CHECK:
            begin
                n_reg <= rd_size_reg;
            end
            bta_pkg::OP_F_LEFT:
            begin
                lf_reg <= (p_reg != '0) && !rd_tag_reg;
                s_reg  <= rd_left_reg;
            end
            bta_pkg::OP_F_RIGHT:
            begin
                tsize_reg <= rd_size_reg;
                q_reg     <= rd_left_reg;
                q1_reg    <= rd_right_reg;
            end
            bta_pkg::OP_N3:
            begin
                q_reg <= rd_left_reg;
            end
            default:
            begin
                k_reg <= k_reg;
            end
        endcase
    end

    assign result = res_reg;

endmodule
`default_nettype wire

@@ rtl/boundary_tag_allocator_top.sv @@
// top level of the boundary-tag first-fit heap allocator
// After reset the block is busy while a clearing pass sets the arena to
// one free block. An allocate loads the request, walks the free list from
// the rover (visiting up to 1024 blocks), then grants the whole block or
// splits it; a free checks the block and is rejected if invalid, else reads
// its neighbours and links it into the free list or merges it. Each arena
// store has a single read and write port. The result word is shown for one
// cycle with done high, the first cycle with busy low, and must be taken
// then; a new start may be given in that same cycle.
`default_nettype none
module boundary_tag_allocator_top (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire bta_pkg::in_word_t           request,
    output logic                             done,
    output bta_pkg::out_word_t               result,
    input  wire logic                        cfg_write_en,
    input  wire logic [bta_pkg::SIZE_W-1:0]  cfg_write_data
);

    bta_pkg::cmd_t cmd;
    bta_pkg::sts_t sts;

    bta_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd),
        .sts   (sts)
    );

    bta_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .request        (request),
        .result         (result),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data)
    );

endmodule
`default_nettype wire

@@ rtl/bta_checker.sv @@
// port-level checker for the allocator handshake and result words
`default_nettype none
module bta_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               start,
    input wire logic               busy,
    input wire logic               done,
    input wire bta_pkg::out_word_t result
);

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result word shown while busy");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done))
        else $error("accepted word did not start work");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status == bta_pkg::STATUS_NO_FIT)) |->
            (result.granted_address == '0))
        else $error("no-fit result carries an address");

endmodule

bind boundary_tag_allocator_top bta_checker u_bta_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);
`default_nettype wire

@@ sim/boundary_tag_allocator_top_test.sv @@
// self-checking testbench for the boundary-tag first-fit heap allocator
`timescale 1ns / 1ps
`default_nettype none
module boundary_tag_allocator_top_test;

    localparam int CYCLE_LIMIT = 5000000;

    logic                          clk;
    logic                          rst_n;
    logic                          start;
    logic                          busy;
    bta_pkg::in_word_t             request;
    logic                          done;
    bta_pkg::out_word_t            result;
    logic                          cfg_write_en;
    logic [bta_pkg::SIZE_W-1:0]    cfg_write_data;

    boundary_tag_allocator_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .request        (request),
        .done           (done),
        .result         (result),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data)
    );

    logic                       heap_tag   [bta_pkg::ARENA_WORDS];
    logic [bta_pkg::SIZE_W-1:0] heap_size  [bta_pkg::ARENA_WORDS];
    logic [bta_pkg::ADDR_W-1:0] heap_left  [bta_pkg::ARENA_WORDS];
    logic [bta_pkg::ADDR_W-1:0] heap_right [bta_pkg::ARENA_WORDS];
    logic [bta_pkg::ADDR_W-1:0] heap_rover;
    logic                       heap_empty;
    logic [bta_pkg::SIZE_W-1:0] slack;

    bta_pkg::out_word_t         pending_words [$];
    logic [bta_pkg::ADDR_W-1:0] live_blocks [$];
    int                         errors;
    int                         cycles;
    int                         n_granted;
    int                         n_no_fit;
    int                         n_frees;
    bit                         quiet_sender;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic void heap_reset();
        for (int i = 0; i < bta_pkg::ARENA_WORDS; i++)
        begin
            heap_tag[i]   = 1'b0;
            heap_size[i]  = '0;
            heap_left[i]  = '0;
            heap_right[i] = '0;
        end
        heap_size[0] = bta_pkg::SIZE_W'(bta_pkg::ARENA_WORDS);
        heap_rover   = '0;
        heap_empty   = 1'b0;
        slack        = bta_pkg::SLACK_RESET;
    endfunction

    function automatic void heap_single(logic [bta_pkg::ADDR_W-1:0] p);
        heap_left[p]  = p;
        heap_right[p] = p;
        heap_rover    = p;
        heap_empty    = 1'b0;
    endfunction

    function automatic bit heap_alloc(logic [bta_pkg::SIZE_W-1:0] n,
                                      output logic [bta_pkg::ADDR_W-1:0] addr);
        logic [bta_pkg::ADDR_W-1:0] first, p, f, nxt, l, f2, q;
        bit found;
        found = 0;
        addr  = '0;
        if (heap_empty || n == 0)
            return 0;
        first = heap_rover;
        p = first;
        for (int k = 0; k < bta_pkg::ARENA_WORDS; k++)
        begin
            if (heap_size[p] >= n)
            begin
                found = 1;
                break;
            end
            p = heap_right[p];
            if (p == first)
                break;
        end
        if (!found)
            return 0;
        f   = bta_pkg::ADDR_W'(p + heap_size[p] - 1);
        nxt = heap_right[p];
        if (bta_pkg::SIZE_W'(heap_size[p] - n) <= slack)
        begin
            if (nxt == p)
            begin
                heap_empty = 1'b1;
                heap_rover = '0;
            end
            else
            begin
                l = heap_left[p];
                heap_left[nxt] = l;
                heap_right[l]  = nxt;
                heap_rover     = nxt;
            end
            heap_tag[p] = 1'b1;
            heap_tag[f] = 1'b1;
            addr = p;
        end
        else
        begin
            heap_rover   = nxt;
            heap_tag[f]  = 1'b1;
            heap_size[p] = heap_size[p] - n;
            f2 = bta_pkg::ADDR_W'(p + heap_size[p] - 1);
            heap_tag[f2]  = 1'b0;
            heap_left[f2] = p;
            q = bta_pkg::ADDR_W'(f2 + 1);
            heap_tag[q]  = 1'b1;
            heap_size[q] = n;
            addr = q;
        end
        return 1;
    endfunction

    function automatic void heap_free(logic [bta_pkg::ADDR_W-1:0] p);
        int n, r;
        bit lf, rf;
        logic [bta_pkg::ADDR_W-1:0] f, s, t, q, q1, r0;
        if (heap_tag[p] == 1'b0 || heap_size[p] == 0 ||
            int'(heap_size[p]) > bta_pkg::ARENA_WORDS - p)
            return;
        n  = heap_size[p];
        r  = p + n;
        lf = (p > 0) && heap_tag[bta_pkg::ADDR_W'(p - 1)] == 1'b0;
        rf = (r < bta_pkg::ARENA_WORDS) && heap_tag[bta_pkg::ADDR_W'(r)] == 1'b0;
        t  = bta_pkg::ADDR_W'(r);
        if (!lf && !rf)
        begin
            heap_tag[p] = 1'b0;
            f = bta_pkg::ADDR_W'(p + n - 1);
            heap_left[f] = p;
            heap_tag[f]  = 1'b0;
            if (heap_empty)
                heap_single(p);
            else
            begin
                r0 = heap_rover;
                q  = heap_left[r0];
                heap_right[p]  = r0;
                heap_left[p]   = q;
                heap_right[q]  = p;
                heap_left[r0]  = p;
                heap_rover     = p;
            end
        end
        else if (lf && !rf)
        begin
            s = heap_left[bta_pkg::ADDR_W'(p - 1)];
            heap_size[s] = bta_pkg::SIZE_W'(heap_size[s] + n);
            f = bta_pkg::ADDR_W'(p + n - 1);
            heap_left[f] = s;
            heap_tag[f]  = 1'b0;
        end
        else if (!lf && rf)
        begin
            heap_tag[p] = 1'b0;
            if (heap_empty || heap_right[t] == t)
                heap_single(p);
            else
            begin
                q  = heap_left[t];
                q1 = heap_right[t];
                heap_left[p]   = q;
                heap_right[q]  = p;
                heap_right[p]  = q1;
                heap_left[q1]  = p;
                if (heap_rover == t)
                    heap_rover = p;
            end
            heap_size[p] = bta_pkg::SIZE_W'(n + heap_size[t]);
            f = bta_pkg::ADDR_W'(p + heap_size[p] - 1);
            heap_left[f] = p;
            heap_tag[f]  = 1'b0;
        end
        else
        begin
            s  = heap_left[bta_pkg::ADDR_W'(p - 1)];
            heap_size[s] = bta_pkg::SIZE_W'(heap_size[s] + n + heap_size[t]);
            q  = heap_left[t];
            q1 = heap_right[t];
            heap_right[q] = q1;
            heap_left[q1] = q;
            if (heap_rover == t)
                heap_rover = s;
            f = bta_pkg::ADDR_W'(t + heap_size[t] - 1);
            heap_left[f] = s;
            heap_tag[f]  = 1'b0;
        end
    endfunction

    function automatic bta_pkg::out_word_t heap_predict(bta_pkg::in_word_t w);
        bta_pkg::out_word_t o;
        logic [bta_pkg::ADDR_W-1:0] a;
        o = '0;
        if (w.func == bta_pkg::FUNC_ALLOC)
        begin
            if (heap_alloc(w.request_size, a))
            begin
                o.status = bta_pkg::STATUS_DONE;
                o.granted_address = a;
                live_blocks.push_back(a);
                n_granted++;
            end
            else
            begin
                o.status = bta_pkg::STATUS_NO_FIT;
                n_no_fit++;
            end
        end
        else
        begin
            heap_free(w.block_address);
            foreach (live_blocks[i])
                if (live_blocks[i] == w.block_address)
                begin
                    live_blocks.delete(i);
                    break;
                end
            n_frees++;
        end
        return o;
    endfunction

    task automatic send_word(input bta_pkg::in_word_t w, output bta_pkg::out_word_t o);
        start   <= 1'b1;
        request <= w;
        do @(posedge clk); while (busy);
        o = heap_predict(w);
        pending_words.push_back(o);
        if (!quiet_sender && $urandom_range(3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(7, 1)) @(posedge clk);
        end
    endtask

    task automatic send_alloc(input int n, output logic [bta_pkg::ADDR_W-1:0] a);
        bta_pkg::in_word_t w;
        bta_pkg::out_word_t o;
        w = '0;
        w.func = bta_pkg::FUNC_ALLOC;
        w.request_size = bta_pkg::SIZE_W'(n);
        w.block_address = bta_pkg::ADDR_W'($urandom);
        send_word(w, o);
        a = o.granted_address;
    endtask

    task automatic send_free(input int p);
        bta_pkg::in_word_t w;
        bta_pkg::out_word_t o;
        w = '0;
        w.func = bta_pkg::FUNC_FREE;
        w.request_size = bta_pkg::SIZE_W'($urandom);
        w.block_address = bta_pkg::ADDR_W'(p);
        send_word(w, o);
    endtask

    task automatic set_slack(input int v);
        start <= 1'b0;
        @(posedge clk);
        while (pending_words.size() != 0 || busy)
            @(posedge clk);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= bta_pkg::SIZE_W'(v);
        @(posedge clk);
        cfg_write_en   <= 1'b0;
        slack = bta_pkg::SIZE_W'(v);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_words.size() == 0)
            begin
                $error("unexpected result word status=%0d granted_address=%0d",
                       result.status, result.granted_address);
                errors++;
            end
            else
            begin
                bta_pkg::out_word_t e;
                e = pending_words.pop_front();
                if (result.status !== e.status)
                begin
                    $error("status: expected %0d, got %0d", e.status, result.status);
                    errors++;
                end
                if (result.granted_address !== e.granted_address)
                begin
                    $error("granted_address: expected %0d, got %0d",
                           e.granted_address, result.granted_address);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic test_directed();
        logic [bta_pkg::ADDR_W-1:0] a, b, c;
        send_alloc(0, a);
        send_alloc(2047, a);
        send_alloc(1025, a);
        send_alloc(1024, a);
        send_alloc(1, a);
        send_free(1023);
        send_free(0);
        send_free(0);
        send_alloc(1020, a);
        send_free(a);
        send_alloc(100, a);
        send_alloc(100, b);
        send_alloc(100, c);
        send_free(a);
        send_free(b);
        send_free(c);
        send_alloc(50, a);
        send_alloc(60, b);
        send_alloc(70, c);
        send_free(b);
        send_free(a);
        send_free(c);
        send_free(1000);
        send_free(511);
        send_free(bta_pkg::ARENA_WORDS - 1);
    endtask

    task automatic test_random(input int count);
        int n, k;
        logic [bta_pkg::ADDR_W-1:0] a;
        for (int i = 0; i < count; i++)
        begin
            k = $urandom_range(99);
            if (k < 50)
            begin
                case ($urandom_range(19))
                    0:       n = $urandom_range(2047);
                    1:       n = $urandom_range(1024, 256);
                    2:       n = 0;
                    default: n = $urandom_range(64, 1);
                endcase
                send_alloc(n, a);
            end
            else if (k < 90 && live_blocks.size() != 0)
                send_free(live_blocks[$urandom_range(live_blocks.size() - 1)]);
            else
                send_free($urandom_range(bta_pkg::ARENA_WORDS - 1));
        end
    endtask

    task automatic test_drain();
        while (live_blocks.size() != 0)
            send_free(live_blocks[0]);
    endtask

    initial
    begin
        clk            = 1'b0;
        start          = 1'b0;
        request        = '0;
        cfg_write_en   = 1'b0;
        cfg_write_data = '0;
        rst_n          = 1'b0;
        errors         = 0;
        cycles         = 0;
        n_granted      = 0;
        n_no_fit       = 0;
        n_frees        = 0;
        quiet_sender   = 0;
        heap_reset();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        set_slack(0);
        test_random(250);
        set_slack(1024);
        test_random(150);
        test_drain();
        set_slack(2047);
        test_random(100);
        set_slack($urandom_range(40, 1));
        test_random(300);
        test_drain();
        set_slack(10);
        test_random(250);
        quiet_sender = 1;
        test_random(150);

        start <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        $display("covered %0d grants, %0d refused allocations and %0d frees",
                 n_granted, n_no_fit, n_frees);
        $display("slack settings 0, 1024, 2047, a random value and 10; all merge cases");
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
`default_nettype wire

@@ sim.f @@
rtl/bta_pkg.sv
rtl/bta_ctrl.sv
rtl/bta_datapath.sv
rtl/boundary_tag_allocator_top.sv
rtl/bta_checker.sv
sim/boundary_tag_allocator_top_test.sv
